// ----- rtl/cpd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types and constants of the checksummed packet deframer.
// ----------------------------------------------------------------------------
package cpd_pkg;

    // Packet byte counter, saturating at all ones
    localparam int unsigned COUNT_W = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Fixed byte values of the framing
    localparam logic [7:0] FLAG_BYTE      = 8'hA0;
    localparam logic [7:0] TRAILER_TARGET = 8'hAA;
    localparam logic [7:0] TRAILER_FIXED  = 8'h88;

    // Reset values of the configuration registers
    localparam logic [7:0] EXPECTED_COMMAND_RST = 8'hB0;
    localparam logic       TRAILER_CHECKSUM_RST = 1'b1;

    // Byte positions within a packet
    localparam logic [COUNT_W-1:0] POS_FLAG     = 17'd0;
    localparam logic [COUNT_W-1:0] POS_OLEN_LO  = 17'd1;
    localparam logic [COUNT_W-1:0] POS_OLEN_HI  = 17'd2;
    localparam logic [COUNT_W-1:0] POS_HCHECK   = 17'd3;
    localparam logic [COUNT_W-1:0] POS_COMMAND  = 17'd4;
    localparam logic [COUNT_W-1:0] POS_ILEN_LO  = 17'd5;
    localparam logic [COUNT_W-1:0] POS_ILEN_HI  = 17'd6;
    localparam logic [COUNT_W-1:0] POS_BODY     = 17'd7;
    localparam logic [COUNT_W-1:0] MIN_SIZE     = 17'd8;
    localparam logic [COUNT_W-1:0] OUTER_EXTRA  = 17'd4;
    localparam logic [15:0]        INNER_EXTRA  = 16'd3;
    localparam logic [15:0]        OUTER_MIN    = 16'd4;

    // Configuration register indexes
    typedef enum logic {
        REG_EXPECTED_COMMAND = 1'b0,
        REG_TRAILER_CHECKSUM = 1'b1
    } cfg_reg_t;

    // Final packet status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_LENGTH   = 2'd1,
        STATUS_INVALID  = 2'd2,
        STATUS_CHECKSUM = 2'd3
    } status_t;

endpackage

// ----- rtl/checksummed_packet_deframer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_packet_deframer_top
// Checks framing, checksums and lengths of a byte stream packet, passes the
// body bytes through and reports one status item per packet.
// ----------------------------------------------------------------------------
// Each input byte is checked against the running packet state at the
// accepting edge and its result, if any, lands in the output register at
// the same edge, so a byte can be accepted every cycle unless the output
// stalls, and a result comes out in the cycle after its byte. Header bytes
// (positions 0 to 6) give no result; later bytes are passed through as body
// items; the byte flagged end_of_packet gives the status item, which is 0
// only for a good packet. The input stalls only while the output register
// holds an item that the sink does not take.
// ----------------------------------------------------------------------------
module checksummed_packet_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wr_data,
    // input byte channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_packet,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_status,
    output logic [7:0]  m_body_byte,
    output logic [1:0]  m_status
);

    // Configuration registers
    logic [7:0] expected_command_reg;
    logic       trailer_checksum_on_reg;

    // Packet state
    logic [cpd_pkg::COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]  header_sum_reg, header_sum_next;
    logic        flags_bad_reg, flags_bad_next;
    logic        header_check_bad_reg, header_check_bad_next;
    logic [15:0] outer_length_reg, outer_length_next;
    logic        command_bad_reg, command_bad_next;
    logic [15:0] inner_length_reg, inner_length_next;
    logic [7:0]  protocol_sum_reg, protocol_sum_next;

    // Output register
    logic        m_valid_reg, m_valid_next;
    logic        m_is_status_reg, m_is_status_next;
    logic [7:0]  m_body_byte_reg, m_body_byte_next;
    logic [1:0]  m_status_reg, m_status_next;

    logic                        s_accept;
    logic [cpd_pkg::COUNT_W-1:0] packet_size;
    logic [7:0]                  trailer_want;
    cpd_pkg::status_t            final_status;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_command_reg    <= cpd_pkg::EXPECTED_COMMAND_RST;
            trailer_checksum_on_reg <= cpd_pkg::TRAILER_CHECKSUM_RST;
        end else if (cfg_wr_en) begin
            unique case (cpd_pkg::cfg_reg_t'(cfg_index))
                cpd_pkg::REG_EXPECTED_COMMAND: expected_command_reg <= cfg_wr_data;
                cpd_pkg::REG_TRAILER_CHECKSUM: trailer_checksum_on_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Work out the packet status for a final byte
    always_comb begin
        packet_size  = (byte_count_reg == cpd_pkg::COUNT_MAX) ? byte_count_reg
                                                              : byte_count_reg + 1'b1;
        trailer_want = trailer_checksum_on_reg ? 8'(cpd_pkg::TRAILER_TARGET - protocol_sum_reg)
                                               : cpd_pkg::TRAILER_FIXED;
        if (packet_size < cpd_pkg::MIN_SIZE) begin
            final_status = cpd_pkg::STATUS_LENGTH;
        end else if (flags_bad_reg) begin
            final_status = cpd_pkg::STATUS_INVALID;
        end else if (header_check_bad_reg) begin
            final_status = cpd_pkg::STATUS_CHECKSUM;
        end else if (outer_length_reg < cpd_pkg::OUTER_MIN
                     || packet_size != {1'b0, outer_length_reg} + cpd_pkg::OUTER_EXTRA) begin
            final_status = cpd_pkg::STATUS_LENGTH;
        end else if (command_bad_reg) begin
            final_status = cpd_pkg::STATUS_INVALID;
        end else if (inner_length_reg == 16'd0
                     || outer_length_reg != 16'(cpd_pkg::INNER_EXTRA + inner_length_reg)) begin
            final_status = cpd_pkg::STATUS_LENGTH;
        end else if (s_data_byte != trailer_want) begin
            final_status = cpd_pkg::STATUS_CHECKSUM;
        end else begin
            final_status = cpd_pkg::STATUS_OK;
        end
    end

    // Advance packet state and load the result for an accepted item
    always_comb begin
        byte_count_next       = byte_count_reg;
        header_sum_next       = header_sum_reg;
        flags_bad_next        = flags_bad_reg;
        header_check_bad_next = header_check_bad_reg;
        outer_length_next     = outer_length_reg;
        command_bad_next      = command_bad_reg;
        inner_length_next     = inner_length_reg;
        protocol_sum_next     = protocol_sum_reg;
        m_valid_next          = m_valid_reg && !m_ready;
        m_is_status_next      = m_is_status_reg;
        m_body_byte_next      = m_body_byte_reg;
        m_status_next         = m_status_reg;

        if (s_accept) begin
            if (s_end_of_packet) begin
                // emit status and clear for the next packet
                m_valid_next          = 1'b1;
                m_is_status_next      = 1'b1;
                m_body_byte_next      = 8'd0;
                m_status_next         = final_status;
                byte_count_next       = '0;
                header_sum_next       = 8'd0;
                flags_bad_next        = 1'b0;
                header_check_bad_next = 1'b0;
                outer_length_next     = 16'd0;
                command_bad_next      = 1'b0;
                inner_length_next     = 16'd0;
                protocol_sum_next     = 8'd0;
            end else begin
                // capture header fields by position
                case (byte_count_reg)
                    cpd_pkg::POS_FLAG:
                        flags_bad_next = (s_data_byte != cpd_pkg::FLAG_BYTE);
                    cpd_pkg::POS_OLEN_LO:
                        outer_length_next = {8'd0, s_data_byte};
                    cpd_pkg::POS_OLEN_HI:
                        outer_length_next = {s_data_byte, outer_length_reg[7:0]};
                    cpd_pkg::POS_HCHECK:
                        header_check_bad_next = (s_data_byte != header_sum_reg);
                    cpd_pkg::POS_COMMAND:
                        command_bad_next = (s_data_byte != expected_command_reg);
                    cpd_pkg::POS_ILEN_LO:
                        inner_length_next = {8'd0, s_data_byte};
                    cpd_pkg::POS_ILEN_HI:
                        inner_length_next = {s_data_byte, inner_length_reg[7:0]};
                    default: ;
                endcase
                if (byte_count_reg < cpd_pkg::POS_HCHECK) begin
                    header_sum_next = header_sum_reg + s_data_byte;
                end
                if (byte_count_reg >= cpd_pkg::POS_COMMAND) begin
                    protocol_sum_next = protocol_sum_reg + s_data_byte;
                end
                if (byte_count_reg != cpd_pkg::COUNT_MAX) begin
                    byte_count_next = byte_count_reg + 1'b1;
                end
                // pass body bytes through
                if (byte_count_reg >= cpd_pkg::POS_BODY) begin
                    m_valid_next     = 1'b1;
                    m_is_status_next = 1'b0;
                    m_body_byte_next = s_data_byte;
                    m_status_next    = cpd_pkg::STATUS_OK;
                end else begin
                    m_valid_next = 1'b0;
                end
            end
        end
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg       <= '0;
            header_sum_reg       <= 8'd0;
            flags_bad_reg        <= 1'b0;
            header_check_bad_reg <= 1'b0;
            outer_length_reg     <= 16'd0;
            command_bad_reg      <= 1'b0;
            inner_length_reg     <= 16'd0;
            protocol_sum_reg     <= 8'd0;
            m_valid_reg          <= 1'b0;
        end else begin
            byte_count_reg       <= byte_count_next;
            header_sum_reg       <= header_sum_next;
            flags_bad_reg        <= flags_bad_next;
            header_check_bad_reg <= header_check_bad_next;
            outer_length_reg     <= outer_length_next;
            command_bad_reg      <= command_bad_next;
            inner_length_reg     <= inner_length_next;
            protocol_sum_reg     <= protocol_sum_next;
            m_valid_reg          <= m_valid_next;
        end
    end

    // Hold result payload
    always_ff @(posedge aclk) begin
        m_is_status_reg <= m_is_status_next;
        m_body_byte_reg <= m_body_byte_next;
        m_status_reg    <= m_status_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_is_status = m_is_status_reg;
    assign m_body_byte = m_body_byte_reg;
    assign m_status    = m_status_reg;

endmodule

// ----- rtl/cpd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module cpd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_end_of_packet,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_is_status,
    input logic [7:0] m_body_byte,
    input logic [1:0] m_status
);

    // A stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_status)
            && $stable(m_body_byte) && $stable(m_status))
        else $error("result item changed while stalled");

    // A final byte gives a status item in the next cycle
    a_status_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_end_of_packet |=> m_valid && m_is_status)
        else $error("no status item after final byte");

    // Unused payload fields stay zero
    a_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_status ? (m_body_byte == 8'd0) : (m_status == 2'd0)))
        else $error("unused result field not zero");

    // No result after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind checksummed_packet_deframer_top cpd_checker u_cpd_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_end_of_packet (s_end_of_packet),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_is_status     (m_is_status),
    .m_body_byte     (m_body_byte),
    .m_status        (m_status)
);

// ----- dv/checksummed_packet_deframer_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_packet_deframer_top_test
// Self-checking testbench of the checksummed packet deframer.
// ----------------------------------------------------------------------------
// Packets are built with correct framing and then damaged on purpose: a bad
// flag byte, header checksum, outer or inner length, command or trailer,
// truncation, extra body bytes or plain noise. Each accepted byte runs
// through a local deframer model that queues the body item or the final
// status it should produce. A monitor pops that queue on every accepted
// result and compares it field by field. Phases change the command and
// trailer mode, the idle rates of both sides, and end with a long good
// packet and a packet whose body runs far past its length fields.
// ----------------------------------------------------------------------------
module checksummed_packet_deframer_top_test;

    typedef logic [7:0] byte_q_t [$];

    typedef struct packed {
        logic             is_status;
        logic [7:0]       body_byte;
        cpd_pkg::status_t status;
    } deframe_result_t;

    // Ways to damage a well-formed packet
    typedef enum int {
        FLAW_NONE,
        FLAW_FLAG,
        FLAW_HEADER_SUM,
        FLAW_OUTER_LEN,
        FLAW_COMMAND,
        FLAW_INNER_LEN,
        FLAW_TRAILER,
        FLAW_TRUNCATE,
        FLAW_EXTRA_BODY,
        FLAW_NOISE
    } flaw_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    cpd_pkg::cfg_reg_t  cfg_index;
    logic [7:0]         cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_data_byte;
    logic               s_end_of_packet;
    logic               m_valid;
    logic               m_ready;
    logic               m_is_status;
    logic [7:0]         m_body_byte;
    logic [1:0]         m_status;

    // Model copy of the registers and the per-packet state
    logic [7:0]                  cmd_setting;
    logic                        trailer_cks_on;
    logic [cpd_pkg::COUNT_W-1:0] pkt_count;
    logic [7:0]                  pkt_header_sum;
    logic                        pkt_flag_bad;
    logic                        pkt_header_bad;
    logic [15:0]                 pkt_outer_len;
    logic                        pkt_command_bad;
    logic [15:0]                 pkt_inner_len;
    logic [7:0]                  pkt_protocol_sum;

    deframe_result_t awaited_items [$];
    int              fail_count;
    int              send_idle_pct;
    int              recv_idle_pct;

    checksummed_packet_deframer_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_packet (s_end_of_packet),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_status     (m_is_status),
        .m_body_byte     (m_body_byte),
        .m_status        (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Bound the run
    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Drive the sink's ready with the current idle rate
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Clear the per-packet state
    task automatic clear_packet_state();
        pkt_count        = '0;
        pkt_header_sum   = '0;
        pkt_flag_bad     = 1'b0;
        pkt_header_bad   = 1'b0;
        pkt_outer_len    = '0;
        pkt_command_bad  = 1'b0;
        pkt_inner_len    = '0;
        pkt_protocol_sum = '0;
    endtask

    // Final status of a packet, first failing check wins
    function automatic cpd_pkg::status_t packet_verdict(
        logic [cpd_pkg::COUNT_W-1:0] size,
        logic [7:0]                  last
    );
        logic [7:0] want_trailer;
        if (size < cpd_pkg::MIN_SIZE) return cpd_pkg::STATUS_LENGTH;
        if (pkt_flag_bad) return cpd_pkg::STATUS_INVALID;
        if (pkt_header_bad) return cpd_pkg::STATUS_CHECKSUM;
        if (pkt_outer_len < cpd_pkg::OUTER_MIN
            || size != {1'b0, pkt_outer_len} + cpd_pkg::OUTER_EXTRA)
            return cpd_pkg::STATUS_LENGTH;
        if (pkt_command_bad) return cpd_pkg::STATUS_INVALID;
        if (pkt_inner_len == 16'd0
            || pkt_outer_len != pkt_inner_len + cpd_pkg::INNER_EXTRA)
            return cpd_pkg::STATUS_LENGTH;
        want_trailer = trailer_cks_on ? cpd_pkg::TRAILER_TARGET - pkt_protocol_sum
                                      : cpd_pkg::TRAILER_FIXED;
        if (last != want_trailer) return cpd_pkg::STATUS_CHECKSUM;
        return cpd_pkg::STATUS_OK;
    endfunction

    // Advance the model by one accepted byte and queue its result, if any
    task automatic deframe_byte(input logic [7:0] b, input logic eop);
        deframe_result_t r;
        logic [cpd_pkg::COUNT_W-1:0] pos;
        logic [cpd_pkg::COUNT_W-1:0] size;
        pos = pkt_count;
        if (eop) begin
            size = (pos < cpd_pkg::COUNT_MAX) ? pos + 1'b1 : cpd_pkg::COUNT_MAX;
            r.is_status = 1'b1;
            r.body_byte = 8'd0;
            r.status    = packet_verdict(size, b);
            awaited_items.push_back(r);
            clear_packet_state();
        end else begin
            case (pos)
                cpd_pkg::POS_FLAG:    pkt_flag_bad = (b != cpd_pkg::FLAG_BYTE);
                cpd_pkg::POS_OLEN_LO: pkt_outer_len = {8'd0, b};
                cpd_pkg::POS_OLEN_HI: pkt_outer_len[15:8] = b;
                cpd_pkg::POS_HCHECK:  pkt_header_bad = (b != pkt_header_sum);
                cpd_pkg::POS_COMMAND: pkt_command_bad = (b != cmd_setting);
                cpd_pkg::POS_ILEN_LO: pkt_inner_len = {8'd0, b};
                cpd_pkg::POS_ILEN_HI: pkt_inner_len[15:8] = b;
                default: ;
            endcase
            if (pos < cpd_pkg::POS_HCHECK) pkt_header_sum = pkt_header_sum + b;
            if (pos >= cpd_pkg::POS_COMMAND) pkt_protocol_sum = pkt_protocol_sum + b;
            if (pkt_count < cpd_pkg::COUNT_MAX) pkt_count = pkt_count + 1'b1;
            if (pos >= cpd_pkg::POS_BODY) begin
                r.is_status = 1'b0;
                r.body_byte = b;
                r.status    = cpd_pkg::STATUS_OK;
                awaited_items.push_back(r);
            end
        end
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : check_results
        deframe_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_items.size() == 0) begin
                $error("unexpected result: is_status %0d body_byte 0x%02h status %0d",
                       m_is_status, m_body_byte, m_status);
                fail_count++;
            end else begin
                want = awaited_items.pop_front();
                if (m_is_status !== want.is_status) begin
                    $error("is_status: expected %0d, got %0d", want.is_status, m_is_status);
                    fail_count++;
                end
                if (m_body_byte !== want.body_byte) begin
                    $error("body_byte: expected 0x%02h, got 0x%02h",
                           want.body_byte, m_body_byte);
                    fail_count++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    fail_count++;
                end
            end
        end
    end

    // Offer one byte after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic eop);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_data_byte     <= b;
        s_end_of_packet <= eop;
        do @(posedge aclk); while (!s_ready);
        deframe_byte(b, eop);
    endtask

    task automatic send_packet(input byte_q_t pkt);
        foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // Drop valid and wait until every expected result is out
    task automatic drain_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (awaited_items.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cpd_pkg::cfg_reg_t idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        case (idx)
            cpd_pkg::REG_EXPECTED_COMMAND: cmd_setting = value;
            cpd_pkg::REG_TRAILER_CHECKSUM: trailer_cks_on = value[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Set the trailer from the protocol bytes before it
    function automatic void seal_trailer(ref byte_q_t pkt);
        logic [7:0] sum;
        sum = 8'd0;
        for (int i = 4; i < pkt.size() - 1; i++) sum = sum + pkt[i];
        pkt[pkt.size()-1] = trailer_cks_on ? cpd_pkg::TRAILER_TARGET - sum
                                           : cpd_pkg::TRAILER_FIXED;
    endfunction

    // Well-formed packet for the current settings
    task automatic build_packet(output byte_q_t pkt, input int n_body);
        logic [15:0] ilen;
        logic [15:0] olen;
        pkt  = {};
        ilen = 16'(n_body + 1);
        olen = ilen + cpd_pkg::INNER_EXTRA;
        pkt.push_back(cpd_pkg::FLAG_BYTE);
        pkt.push_back(olen[7:0]);
        pkt.push_back(olen[15:8]);
        pkt.push_back(cpd_pkg::FLAG_BYTE + olen[7:0] + olen[15:8]);
        pkt.push_back(cmd_setting);
        pkt.push_back(ilen[7:0]);
        pkt.push_back(ilen[15:8]);
        repeat (n_body) pkt.push_back(8'($urandom));
        pkt.push_back(8'd0);
        seal_trailer(pkt);
    endtask

    // Random packet, well-formed about half the time
    task automatic make_random_packet(output byte_q_t pkt);
        flaw_t       flaw;
        int          n_body;
        int          k;
        logic [7:0]  flip;
        logic [15:0] olen;
        n_body = ($urandom_range(15) == 0) ? $urandom_range(40) : $urandom_range(8);
        build_packet(pkt, n_body);
        flip = 8'($urandom_range(255, 1));
        flaw = ($urandom_range(99) < 50) ? FLAW_NONE : flaw_t'($urandom_range(1, FLAW_NOISE));
        case (flaw)
            FLAW_FLAG:       pkt[0] ^= flip;
            FLAW_HEADER_SUM: pkt[3] ^= flip;
            FLAW_OUTER_LEN: begin
                pkt[1 + $urandom_range(1)] ^= flip;
                pkt[3] = pkt[0] + pkt[1] + pkt[2];
            end
            FLAW_COMMAND:    pkt[4] ^= flip;
            FLAW_INNER_LEN: begin
                pkt[5 + $urandom_range(1)] ^= flip;
                seal_trailer(pkt);
            end
            FLAW_TRAILER:    pkt[pkt.size()-1] ^= flip;
            FLAW_TRUNCATE: begin
                k = $urandom_range(pkt.size() - 1, 1);
                repeat (k) void'(pkt.pop_back());
            end
            FLAW_EXTRA_BODY: begin
                // outer length still agrees, inner length falls short
                k = $urandom_range(6, 1);
                repeat (k) pkt.insert(pkt.size() - 1, 8'($urandom));
                olen = 16'({pkt[2], pkt[1]} + k);
                pkt[1] = olen[7:0];
                pkt[2] = olen[15:8];
                pkt[3] = pkt[0] + pkt[1] + pkt[2];
                seal_trailer(pkt);
            end
            FLAW_NOISE: begin
                pkt = {};
                repeat ($urandom_range(12, 1)) pkt.push_back(8'($urandom));
            end
            default: ;
        endcase
    endtask

    // One-byte packet, minimal good packet, body bytes at both extremes
    task automatic test_directed();
        byte_q_t pkt;
        send_byte(8'hFF, 1'b1);
        build_packet(pkt, 0);
        send_packet(pkt);
        build_packet(pkt, 2);
        pkt[7] = 8'h00;
        pkt[8] = 8'hFF;
        seal_trailer(pkt);
        send_packet(pkt);
    endtask

    // Mixed good and damaged packets, with one full pause halfway
    task automatic test_random_traffic(input int n_items);
        byte_q_t pkt;
        int      sent;
        bit      paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            make_random_packet(pkt);
            send_packet(pkt);
            sent += pkt.size();
            if (!paused && sent >= n_items / 2) begin
                drain_block();
                paused = 1'b1;
            end
        end
    endtask

    // Long good packet, then one whose body runs far past its length fields
    task automatic test_long_packets();
        byte_q_t pkt;
        build_packet(pkt, 120);
        send_packet(pkt);
        for (int i = 0; i < int'(cpd_pkg::POS_BODY); i++) send_byte(pkt[i], 1'b0);
        repeat (100) send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b1);
    endtask

    initial begin
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = cpd_pkg::REG_EXPECTED_COMMAND;
        cfg_wr_data     = 8'd0;
        s_valid         = 1'b0;
        s_data_byte     = 8'd0;
        s_end_of_packet = 1'b0;
        fail_count      = 0;
        send_idle_pct   = 13;
        recv_idle_pct   = 52;
        cmd_setting     = cpd_pkg::EXPECTED_COMMAND_RST;
        trailer_cks_on  = cpd_pkg::TRAILER_CHECKSUM_RST;
        clear_packet_state();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Sender idles rarely, sink often
        test_directed();
        drain_block();
        write_reg(cpd_pkg::REG_EXPECTED_COMMAND, 8'h00);
        write_reg(cpd_pkg::REG_TRAILER_CHECKSUM, 8'h00);
        test_random_traffic(400);
        drain_block();

        // Sender idles often, sink rarely
        send_idle_pct = 52;
        recv_idle_pct = 13;
        write_reg(cpd_pkg::REG_EXPECTED_COMMAND, 8'hFF);
        write_reg(cpd_pkg::REG_TRAILER_CHECKSUM, 8'hFF);
        test_random_traffic(400);
        drain_block();

        // Full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(cpd_pkg::REG_EXPECTED_COMMAND, 8'($urandom));
        write_reg(cpd_pkg::REG_TRAILER_CHECKSUM, 8'h00);
        test_random_traffic(300);
        test_long_packets();

        // Let the last results out, then give the verdict
        @(negedge aclk);
        s_valid <= 1'b0;
        for (int i = 0; i < 10000 && awaited_items.size() != 0; i++) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (awaited_items.size() != 0) begin
            $error("%0d expected results never arrived", awaited_items.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
